// ===== design/crc32_frame_codec_top_macros.svh =====
// ----------------------------------------------------------------------------
// crc32_frame_codec_top assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CRC32_FRAME_CODEC_TOP_MACROS_SVH
`define CRC32_FRAME_CODEC_TOP_MACROS_SVH

// check a condition at every clock edge out of reset
`define CFC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// check that a trigger is followed by a condition on the next edge
`define CFC_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== design/cfc_pkg.sv =====
// ----------------------------------------------------------------------------
// cfc_pkg
// Types, codes, constants and the CRC-32/MPEG-2 word update for the codec.
// ----------------------------------------------------------------------------
package cfc_pkg;

    localparam int DATA_WORDS_DEF  = 6;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int POS_W           = 4;

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic
    {
        OP_TX = 1'b0,
        OP_RX = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        KIND_TX     = 2'd0,
        KIND_RX     = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0]
    {
        CMD_TX_WORD   = 3'd0,
        CMD_TX_LAST   = 3'd1,
        CMD_RX_STORE  = 3'd2,
        CMD_RX_ACCEPT = 3'd3,
        CMD_RX_REJECT = 3'd4
    } cmd_op_t;

    typedef struct packed
    {
        cmd_op_t           op;
        logic [POS_W-1:0]  pos;
        logic [31:0]       word;
        logic [31:0]       crc;
    } cmd_t;

    typedef struct packed
    {
        logic push;
        cmd_t cmd;
    } push_t;

    typedef struct packed
    {
        logic valid;
        cmd_t cmd;
    } head_t;

    function automatic logic [31:0] crc32_word(input logic [31:0] crc,
                                               input logic [31:0] w);
        logic [31:0] c;
        c = crc ^ w;
        for (int b = 0; b < 32; b++)
        begin
            c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

// ===== design/cfc_ifs.sv =====
// ----------------------------------------------------------------------------
// cfc_ifs
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface cfc_item_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] word;

    modport source(output valid, opcode, word, input ready);
    modport sink(input valid, opcode, word, output ready);
endinterface

interface cfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] frame_word;
    logic [2:0]  word_index;
    logic        last;

    modport source(output valid, kind, frame_word, word_index, last, input ready);
    modport sink(input valid, kind, frame_word, word_index, last, output ready);
endinterface

// ===== design/crc32_frame_codec_top.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_codec_top
// Frames outbound words with a CRC-32/MPEG-2 word and checks inbound frames.
// ----------------------------------------------------------------------------
// The codec takes one word per cycle on item while its command queue has
// room. The front updates the transmit or receive CRC for a word in that same
// cycle and queues one command; the back turns commands into results through
// a single result register, one result per cycle while the result channel is
// ready. A transmit word gives one result, the word that closes a transmit
// frame gives two, a stored receive word is taken by the back with no result,
// and a receive frame that checks clean drains DATA_WORDS + 1 results; a
// rejected frame gives one. The QUEUE_DEPTH-entry queue lets the front keep
// taking words while the back drains a burst.
module crc32_frame_codec_top #(
    parameter int DATA_WORDS  = cfc_pkg::DATA_WORDS_DEF,
    parameter int QUEUE_DEPTH = cfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    cfc_item_if.sink     item,
    cfc_result_if.source result
);

    cfc_pkg::push_t push;
    cfc_pkg::head_t head;
    logic           full;
    logic           pop;

    cfc_front #(
        .DATA_WORDS(DATA_WORDS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .full  (full),
        .push  (push)
    );

    cfc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .pop   (pop),
        .head  (head)
    );

    cfc_back #(
        .DATA_WORDS(DATA_WORDS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// ===== design/cfc_front.sv =====
// ----------------------------------------------------------------------------
// cfc_front
// Accepts input words, runs both CRCs and issues one command per word.
// ----------------------------------------------------------------------------
module cfc_front #(
    parameter int DATA_WORDS = cfc_pkg::DATA_WORDS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    cfc_item_if.sink          item,
    input  logic              full,
    output cfc_pkg::push_t    push
);

    localparam logic [cfc_pkg::POS_W-1:0] TX_END  = cfc_pkg::POS_W'(DATA_WORDS);
    localparam logic [cfc_pkg::POS_W-1:0] RX_KEEP = cfc_pkg::POS_W'(DATA_WORDS + 1);

    logic [cfc_pkg::POS_W-1:0] tx_pos_reg, tx_pos_next;
    logic [cfc_pkg::POS_W-1:0] rx_pos_reg, rx_pos_next;
    logic [31:0]               tx_crc_reg, tx_crc_next;
    logic [31:0]               rx_crc_reg, rx_crc_next;
    logic                      accept;
    logic [31:0]               crc_upd;
    cfc_pkg::cmd_t             cmd;

    assign item.ready = !full;
    assign accept     = item.valid && item.ready;
    assign crc_upd    = cfc_pkg::crc32_word(
        (item.opcode == cfc_pkg::OP_TX) ? tx_crc_reg : rx_crc_reg, item.word);

    always_comb
    begin
        tx_pos_next = tx_pos_reg;
        rx_pos_next = rx_pos_reg;
        tx_crc_next = tx_crc_reg;
        rx_crc_next = rx_crc_reg;
        cmd.word    = item.word;
        cmd.crc     = crc_upd;
        if (item.opcode == cfc_pkg::OP_TX)
        begin
            cmd.pos = tx_pos_reg;
            if (tx_pos_reg >= TX_END)
            begin
                cmd.op      = cfc_pkg::CMD_TX_LAST;
                tx_pos_next = '0;
                tx_crc_next = cfc_pkg::CRC_INIT;
            end
            else
            begin
                cmd.op      = cfc_pkg::CMD_TX_WORD;
                tx_pos_next = tx_pos_reg + 1'b1;
                tx_crc_next = crc_upd;
            end
        end
        else
        begin
            cmd.pos = rx_pos_reg;
            if (rx_pos_reg < RX_KEEP)
            begin
                cmd.op      = cfc_pkg::CMD_RX_STORE;
                rx_pos_next = rx_pos_reg + 1'b1;
                rx_crc_next = crc_upd;
            end
            else
            begin
                cmd.op      = (crc_upd == '0) ? cfc_pkg::CMD_RX_ACCEPT
                                              : cfc_pkg::CMD_RX_REJECT;
                rx_pos_next = '0;
                rx_crc_next = cfc_pkg::CRC_INIT;
            end
        end
    end

    assign push.push = accept;
    assign push.cmd  = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_pos_reg <= '0;
            rx_pos_reg <= '0;
            tx_crc_reg <= cfc_pkg::CRC_INIT;
            rx_crc_reg <= cfc_pkg::CRC_INIT;
        end
        else if (accept)
        begin
            tx_pos_reg <= tx_pos_next;
            rx_pos_reg <= rx_pos_next;
            tx_crc_reg <= tx_crc_next;
            rx_crc_reg <= rx_crc_next;
        end
    end

endmodule

// ===== design/cfc_queue.sv =====
// ----------------------------------------------------------------------------
// cfc_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module cfc_queue #(
    parameter int DEPTH = cfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfc_pkg::push_t push,
    output logic           full,
    input  logic           pop,
    output cfc_pkg::head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cfc_pkg::cmd_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_FULL);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push.push && !full;
    assign do_pop     = pop && head.valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/cfc_back.sv =====
// ----------------------------------------------------------------------------
// cfc_back
// Executes commands: holds the receive words and emits result words.
// ----------------------------------------------------------------------------
`include "crc32_frame_codec_top_macros.svh"

module cfc_back #(
    parameter int DATA_WORDS = cfc_pkg::DATA_WORDS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfc_pkg::head_t head,
    output logic           pop,
    cfc_result_if.source   result
);

    localparam int STORE_WORDS = DATA_WORDS + 1;
    localparam int IDX_W       = $clog2(STORE_WORDS);
    localparam logic [IDX_W-1:0] BEAT_LAST = IDX_W'(STORE_WORDS - 1);
    localparam logic [2:0]       CRC_INDEX = 3'(DATA_WORDS + 1);

    logic [31:0]       store_reg [STORE_WORDS];
    logic [IDX_W-1:0]  beat_reg, beat_next;
    logic              out_valid_reg, out_valid_next;
    cfc_pkg::kind_t    out_kind_reg, out_kind_next;
    logic [31:0]       out_word_reg, out_word_next;
    logic [2:0]        out_index_reg, out_index_next;
    logic              out_last_reg, out_last_next;
    logic              can_emit;
    logic              store_we;

    assign can_emit = !out_valid_reg || result.ready;

    always_comb
    begin
        pop            = 1'b0;
        store_we       = 1'b0;
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_kind_next  = out_kind_reg;
        out_word_next  = out_word_reg;
        out_index_next = out_index_reg;
        out_last_next  = out_last_reg;
        if (head.valid)
        begin
            unique case (head.cmd.op)
                cfc_pkg::CMD_RX_STORE:
                begin
                    store_we = 1'b1;
                    pop      = 1'b1;
                end
                cfc_pkg::CMD_TX_WORD:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = cfc_pkg::KIND_TX;
                        out_word_next  = head.cmd.word;
                        out_index_next = head.cmd.pos[2:0];
                        out_last_next  = 1'b0;
                        pop            = 1'b1;
                    end
                end
                cfc_pkg::CMD_TX_LAST:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = cfc_pkg::KIND_TX;
                        if (beat_reg == '0)
                        begin
                            out_word_next  = head.cmd.word;
                            out_index_next = head.cmd.pos[2:0];
                            out_last_next  = 1'b0;
                            beat_next      = IDX_W'(1);
                        end
                        else
                        begin
                            out_word_next  = head.cmd.crc;
                            out_index_next = CRC_INDEX;
                            out_last_next  = 1'b1;
                            beat_next      = '0;
                            pop            = 1'b1;
                        end
                    end
                end
                cfc_pkg::CMD_RX_ACCEPT:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = cfc_pkg::KIND_RX;
                        out_word_next  = store_reg[beat_reg];
                        out_index_next = 3'(beat_reg);
                        out_last_next  = (beat_reg == BEAT_LAST);
                        if (beat_reg == BEAT_LAST)
                        begin
                            beat_next = '0;
                            pop       = 1'b1;
                        end
                        else
                        begin
                            beat_next = beat_reg + 1'b1;
                        end
                    end
                end
                cfc_pkg::CMD_RX_REJECT:
                begin
                    if (can_emit)
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = cfc_pkg::KIND_REJECT;
                        out_word_next  = '0;
                        out_index_next = '0;
                        out_last_next  = 1'b1;
                        pop            = 1'b1;
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[head.cmd.pos[IDX_W-1:0]] <= head.cmd.word;
        end
        out_kind_reg  <= out_kind_next;
        out_word_reg  <= out_word_next;
        out_index_reg <= out_index_next;
        out_last_reg  <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.kind       = out_kind_reg;
    assign result.frame_word = out_word_reg;
    assign result.word_index = out_index_reg;
    assign result.last       = out_last_reg;

    `CFC_ASSERT_ALWAYS(a_beat_range, beat_reg <= BEAT_LAST, "burst beat out of range")
    `CFC_ASSERT_NEXT(a_crc_follows,
        head.valid && head.cmd.op == cfc_pkg::CMD_TX_LAST && beat_reg != '0 && can_emit,
        out_valid_reg && out_last_reg && out_word_reg == $past(head.cmd.crc),
        "CRC word not emitted as last")
    `CFC_ASSERT_NEXT(a_accept_last,
        head.valid && head.cmd.op == cfc_pkg::CMD_RX_ACCEPT && can_emit,
        out_last_reg == ($past(beat_reg) == BEAT_LAST),
        "receive burst last flag misplaced")

endmodule
